/* rtl/tcrq_pkg.sv */
// ----------------------------------------------------------------------------
// tcrq_pkg
// Shared types and constants for the timed command release queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tcrq_pkg;

  localparam int unsigned QUEUE_DEPTH = 64;

  localparam logic [31:0] WINDOW_RESET = 32'd1000000;

  localparam logic [2:0]  CT_NOP    = 3'd0;
  localparam logic        OP_INSERT = 1'b0;
  localparam logic        OP_TICK   = 1'b1;
  localparam logic        STAT_RELEASED = 1'b0;
  localparam logic        STAT_FULL     = 1'b1;

  typedef struct packed {
    logic [2:0]  cmd_type;
    logic [15:0] query;
    logic [47:0] exec_time;
    logic [31:0] exec_length;
    logic [47:0] ref_time;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t ent;
  } cell_cmd_t;

  typedef struct packed {
    logic                   head_vld;
    entry_t                 head;
    logic                   next_vld;
    logic [47:0]            next_time;
    logic                   full;
    logic [QUEUE_DEPTH-1:0] vld;
  } chain_stat_t;

  typedef enum logic {
    ST_IDLE,
    ST_TICK
  } state_t;

endpackage

`default_nettype wire

/* rtl/timed_command_release_queue_unit.sv */
// ----------------------------------------------------------------------------
// timed_command_release_queue_unit
// Time-ordered command queue built as a chain of cells; ticks release the
// commands that fall due, earliest first.
// ----------------------------------------------------------------------------
// Insert: enters the chain on acceptance; in_ready stays high while the output
//   register is free; a full-queue drop puts its word there on acceptance.
// Tick: the limit is registered first, then one released word per cycle
//   leaves the head cell while the receiver takes them, until nothing more
//   is due; nothing is released when no command falls due.
// Reset (rst_n low, synchronous): queue empty, window 1000000, output empty.
`default_nettype none

module timed_command_release_queue_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_opcode,
  input  wire  [2:0]  in_cmd_type,
  input  wire  [15:0] in_query,
  input  wire  [47:0] in_exec_time,
  input  wire  [31:0] in_exec_length,
  input  wire  [47:0] in_ref_time,
  input  wire  [47:0] in_tick_time,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [31:0] cfg_data,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        out_status,
  output logic [2:0]  out_type,
  output logic [15:0] out_query,
  output logic [47:0] out_exec_time,
  output logic [31:0] out_length,
  output logic [47:0] out_ref_time,
  output logic        out_last
);
  import tcrq_pkg::*;

  state_t      state_r, state_nxt;
  logic [31:0] window_r;
  logic [48:0] limit_r, limit_nxt;
  logic        out_vld_r, out_vld_nxt;
  logic        stat_r, stat_nxt;
  entry_t      oent_r, oent_nxt;
  logic        last_r, last_nxt;

  cell_cmd_t   cmd;
  chain_stat_t cst;
  logic        out_free, acc, due_head, due_next;

  tcrq_chain u_chain (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .stat (cst)
  );

  assign cfg_ready = 1'b1;
  assign out_free  = !out_vld_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign acc       = in_valid && in_ready;
  assign due_head  = cst.head_vld && ({1'b0, cst.head.exec_time} < limit_r);
  assign due_next  = cst.next_vld && ({1'b0, cst.next_time} < limit_r);

  always_comb begin
    state_nxt     = state_r;
    limit_nxt     = limit_r;
    cmd.ins       = 1'b0;
    cmd.pop       = 1'b0;
    cmd.ent       = '{cmd_type: in_cmd_type, query: in_query,
                      exec_time: in_exec_time, exec_length: in_exec_length,
                      ref_time: in_ref_time};
    out_vld_nxt   = out_ready ? 1'b0 : out_vld_r;
    stat_nxt      = stat_r;
    oent_nxt      = oent_r;
    last_nxt      = last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_opcode == OP_TICK) begin
            limit_nxt = {1'b0, in_tick_time} + {17'd0, window_r};
            state_nxt = ST_TICK;
          end else if (in_cmd_type != CT_NOP) begin
            if (cst.full) begin
              out_vld_nxt = 1'b1;
              stat_nxt    = STAT_FULL;
              oent_nxt    = '0;
              last_nxt    = 1'b1;
            end else begin
              cmd.ins = 1'b1;
            end
          end
        end
      end
      ST_TICK: begin
        if (out_free) begin
          if (due_head) begin
            cmd.pop     = 1'b1;
            out_vld_nxt = 1'b1;
            stat_nxt    = STAT_RELEASED;
            oent_nxt    = cst.head;
            last_nxt    = !due_next;
            if (!due_next) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            // nothing due at all
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
      window_r  <= WINDOW_RESET;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        window_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    limit_r <= limit_nxt;
    stat_r  <= stat_nxt;
    oent_r  <= oent_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid     = out_vld_r;
  assign out_status    = stat_r;
  assign out_type      = oent_r.cmd_type;
  assign out_query     = oent_r.query;
  assign out_exec_time = oent_r.exec_time;
  assign out_length    = oent_r.exec_length;
  assign out_ref_time  = oent_r.ref_time;
  assign out_last      = last_r;

  // occupied cells form an unbroken run from the head
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (cst.vld & (cst.vld + 1'b1)) == '0)
    else $error("occupied cells not contiguous");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    cst.next_vld |-> (cst.head.exec_time <= cst.next_time))
    else $error("head later than second cell");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TICK) |-> !in_ready)
    else $error("input taken during release");

  a_full_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && stat_r == STAT_FULL) |-> last_r)
    else $error("overflow word without last");

endmodule

`default_nettype wire

/* rtl/tcrq_cell.sv */
// ----------------------------------------------------------------------------
// tcrq_cell
// One slot of the sorted chain: holds an entry, shifts right on insert and
// left on release.
// ----------------------------------------------------------------------------
`default_nettype none

module tcrq_cell (
  input  wire                   clk,
  input  wire                   rst_n,
  input  tcrq_pkg::cell_cmd_t   cmd,
  input  wire                   left_vld,
  input  tcrq_pkg::entry_t      left_ent,
  input  wire                   left_disp,
  input  wire                   right_vld,
  input  tcrq_pkg::entry_t      right_ent,
  output logic                  vld,
  output tcrq_pkg::entry_t      ent,
  output logic                  disp
);
  import tcrq_pkg::*;

  logic   vld_r, vld_nxt;
  entry_t ent_r, ent_nxt;

  // slot gives way to the new word if empty or strictly later
  assign disp = !vld_r || (ent_r.exec_time > cmd.ent.exec_time);

  always_comb begin
    vld_nxt = vld_r;
    ent_nxt = ent_r;
    if (cmd.pop) begin
      vld_nxt = right_vld;
      ent_nxt = right_ent;
    end else if (cmd.ins && disp) begin
      if (left_disp) begin
        vld_nxt = left_vld;
        ent_nxt = left_ent;
      end else begin
        vld_nxt = 1'b1;
        ent_nxt = cmd.ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign vld = vld_r;
  assign ent = ent_r;

endmodule

`default_nettype wire

/* rtl/tcrq_chain.sv */
// ----------------------------------------------------------------------------
// tcrq_chain
// Row of cells kept in ascending execution time, head at cell 0.
// ----------------------------------------------------------------------------
`default_nettype none

module tcrq_chain (
  input  wire                    clk,
  input  wire                    rst_n,
  input  tcrq_pkg::cell_cmd_t    cmd,
  output tcrq_pkg::chain_stat_t  stat
);
  import tcrq_pkg::*;

  logic   [QUEUE_DEPTH-1:0] vld;
  logic   [QUEUE_DEPTH-1:0] disp;
  entry_t                   ent [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   l_vld, l_disp, r_vld;
    entry_t l_ent, r_ent;

    if (i == 0) begin : g_first
      assign l_vld  = 1'b0;
      assign l_disp = 1'b0;
      assign l_ent  = '0;
    end else begin : g_mid_l
      assign l_vld  = vld[i-1];
      assign l_disp = disp[i-1];
      assign l_ent  = ent[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign r_vld = 1'b0;
      assign r_ent = '0;
    end else begin : g_mid_r
      assign r_vld = vld[i+1];
      assign r_ent = ent[i+1];
    end

    tcrq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_vld  (l_vld),
      .left_ent  (l_ent),
      .left_disp (l_disp),
      .right_vld (r_vld),
      .right_ent (r_ent),
      .vld       (vld[i]),
      .ent       (ent[i]),
      .disp      (disp[i])
    );
  end

  assign stat.head_vld  = vld[0];
  assign stat.head      = ent[0];
  assign stat.next_vld  = vld[1];
  assign stat.next_time = ent[1].exec_time;
  assign stat.full      = vld[QUEUE_DEPTH-1];
  assign stat.vld       = vld;

endmodule

`default_nettype wire
